// ----- src/pwcr_pkg.sv -----
package pwcr_pkg;

    // Default sizes of the palette and of the water color run.
    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int WATER_SPAN_DEF      = 4;

    // Fixed field widths.
    localparam int CHAN_W      = 8;
    localparam int ENTRY_IDX_W = 4;
    localparam int ENTRY_SLOTS = 1 << ENTRY_IDX_W;
    localparam int BASE_W      = 4;
    localparam int MOD_W       = 4;
    localparam int WIDX_W      = 5;
    localparam int DIST_W      = 18;
    localparam int QUANT_SHIFT = 4;

    // The largest water index is 15 + 15, so a small palette wraps at most this often.
    localparam int WIDX_MAX  = 30;
    localparam int MAX_WRAPS = 8;

    localparam logic [BASE_W-1:0] WATER_BASE_RST = BASE_W'(8);

    // Item kinds carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              mask;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [DIST_W-1:0] best_d;
        logic [MOD_W-1:0]  best_mod;
    } t_srch;

    typedef struct packed {
        logic              valid;
        logic              mask;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [WIDX_W-1:0] widx;
    } t_fetch;

endpackage

// ----- src/pwcr_cell.sv -----
module pwcr_cell #(
    parameter int CELL_INDEX      = 0,
    parameter int PALETTE_ENTRIES = 16,
    parameter int WATER_SPAN      = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_wr_en,
    input  logic [pwcr_pkg::ENTRY_IDX_W-1:0]     i_wr_index,
    input  logic [3*pwcr_pkg::CHAN_W-1:0]        i_wr_data,
    input  pwcr_pkg::t_srch                      i_srch,
    output pwcr_pkg::t_srch                      o_srch,
    input  pwcr_pkg::t_fetch                     i_fetch,
    output pwcr_pkg::t_fetch                     o_fetch,
    output logic                                 o_busy
);
    import pwcr_pkg::*;

    localparam bit              WRITABLE = CELL_INDEX < ENTRY_SLOTS;
    localparam logic [MOD_W-1:0] CELL_MOD = MOD_W'(CELL_INDEX % WATER_SPAN);

    logic [3*CHAN_W-1:0] r_entry;
    t_srch               r_srch;
    t_srch               n_srch;
    t_fetch              r_fetch;
    t_fetch              n_fetch;

    logic signed [CHAN_W:0]   w_dr;
    logic signed [CHAN_W:0]   w_dg;
    logic signed [CHAN_W:0]   w_db;
    logic signed [DIST_W-1:0] w_pr;
    logic signed [DIST_W-1:0] w_pg;
    logic signed [DIST_W-1:0] w_pb;
    logic [DIST_W-1:0]        w_dist;
    logic                     w_fetch_hit;

    always_ff @(posedge i_clk) begin
        if (WRITABLE && i_wr_en && (i_wr_index == ENTRY_IDX_W'(CELL_INDEX))) begin
            r_entry <= i_wr_data;
        end
    end

    // Distance from this entry to the color reduced to its top four bits per channel.
    always_comb begin
        w_dr = $signed({1'b0, r_entry[23:16]})
             - $signed({1'b0, i_srch.red[7:QUANT_SHIFT], QUANT_SHIFT'(0)});
        w_dg = $signed({1'b0, r_entry[15:8]})
             - $signed({1'b0, i_srch.green[7:QUANT_SHIFT], QUANT_SHIFT'(0)});
        w_db = $signed({1'b0, r_entry[7:0]})
             - $signed({1'b0, i_srch.blue[7:QUANT_SHIFT], QUANT_SHIFT'(0)});
        w_pr = w_dr * w_dr;
        w_pg = w_dg * w_dg;
        w_pb = w_db * w_db;
        w_dist = DIST_W'(w_pr[15:0]) + DIST_W'(w_pg[15:0]) + DIST_W'(w_pb[15:0]);
    end

    always_comb begin
        n_srch = i_srch;
        // The first cell always takes its entry; later cells need a strictly smaller distance.
        if ((CELL_INDEX == 0) || (w_dist < i_srch.best_d)) begin
            n_srch.best_d   = w_dist;
            n_srch.best_mod = CELL_MOD;
        end
    end

    // A small palette wraps the water index, so several index values map onto this entry.
    always_comb begin
        w_fetch_hit = 1'b0;
        for (int k = 0; k < MAX_WRAPS; k++) begin
            if ((CELL_INDEX + k * PALETTE_ENTRIES <= WIDX_MAX)
                && (i_fetch.widx == WIDX_W'(CELL_INDEX + k * PALETTE_ENTRIES))) begin
                w_fetch_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_fetch = i_fetch;
        if (i_fetch.mask && w_fetch_hit) begin
            n_fetch.red   = r_entry[23:16];
            n_fetch.green = r_entry[15:8];
            n_fetch.blue  = r_entry[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srch.valid  <= 1'b0;
            r_fetch.valid <= 1'b0;
        end else if (i_adv) begin
            r_srch  <= n_srch;
            r_fetch <= n_fetch;
        end
    end

    assign o_srch  = r_srch;
    assign o_fetch = r_fetch;
    assign o_busy  = r_srch.valid || r_fetch.valid;

endmodule

// ----- src/palette_water_color_remap_top.sv -----
// A pixel beat passes each palette cell's search register, then each cell's fetch register,
// then the output register. Throughput: one pixel per cycle while the output is not stalled
// and no load is parked; the row of palette cells is walked twice, once to find the nearest entry
// and once to fetch the water color, one cell per cycle. A palette load waits until no pixel is
// inside the cell row and is then written; the input is held off meanwhile.
// Reset (synchronous, active low) empties the pipeline and sets water_base to 8;
// palette entries are not cleared.
module palette_water_color_remap_top #(
    parameter int PALETTE_ENTRIES = pwcr_pkg::PALETTE_ENTRIES_DEF,
    parameter int WATER_SPAN      = pwcr_pkg::WATER_SPAN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_index[3:0], red[11:4], green[19:12], blue[27:20], alpha[35:28], zero pad
    input  logic [39:0]                   s_axis_tdata,
    // opcode[0], mask_on[1]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0]                   m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwcr_pkg::BASE_W-1:0]   i_cfg_data
);
    import pwcr_pkg::*;

    logic [BASE_W-1:0]      r_water_base;
    logic                   r_ld_valid;
    logic [ENTRY_IDX_W-1:0] r_ld_index;
    logic [3*CHAN_W-1:0]    r_ld_data;
    logic                   r_out_valid;
    logic [31:0]            r_out;

    logic                       w_adv;
    logic                       w_in_beat;
    logic                       w_busy;
    logic                       w_commit;
    logic [PALETTE_ENTRIES-1:0] w_busy_vec;
    t_srch                      w_srch  [0:PALETTE_ENTRIES];
    t_fetch                     w_fetch [0:PALETTE_ENTRIES];

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv && !r_ld_valid;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_busy        = |w_busy_vec;
    assign w_commit      = r_ld_valid && !w_busy;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water_base <= WATER_BASE_RST;
        end else if (i_cfg_valid) begin
            r_water_base <= i_cfg_data;
        end
    end

    // A load is parked here until pixels already in the row have read the palette.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_valid <= 1'b0;
        end else if (w_in_beat && (s_axis_tuser[0] == OP_LOAD)) begin
            r_ld_valid <= 1'b1;
        end else if (w_commit) begin
            r_ld_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat && (s_axis_tuser[0] == OP_LOAD)) begin
            r_ld_index <= s_axis_tdata[3:0];
            r_ld_data  <= {s_axis_tdata[11:4], s_axis_tdata[19:12], s_axis_tdata[27:20]};
        end
    end

    always_comb begin
        w_srch[0]          = '0;
        w_srch[0].valid    = w_in_beat && (s_axis_tuser[0] == OP_PIXEL);
        w_srch[0].mask     = s_axis_tuser[1];
        w_srch[0].red      = s_axis_tdata[11:4];
        w_srch[0].green    = s_axis_tdata[19:12];
        w_srch[0].blue     = s_axis_tdata[27:20];
        w_srch[0].alpha    = s_axis_tdata[35:28];
    end

    always_comb begin
        w_fetch[0].valid = w_srch[PALETTE_ENTRIES].valid;
        w_fetch[0].mask  = w_srch[PALETTE_ENTRIES].mask;
        w_fetch[0].red   = w_srch[PALETTE_ENTRIES].red;
        w_fetch[0].green = w_srch[PALETTE_ENTRIES].green;
        w_fetch[0].blue  = w_srch[PALETTE_ENTRIES].blue;
        w_fetch[0].alpha = w_srch[PALETTE_ENTRIES].alpha;
        w_fetch[0].widx  = WIDX_W'(r_water_base) + WIDX_W'(w_srch[PALETTE_ENTRIES].best_mod);
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        pwcr_cell #(
            .CELL_INDEX      (g),
            .PALETTE_ENTRIES (PALETTE_ENTRIES),
            .WATER_SPAN      (WATER_SPAN)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_wr_en    (w_commit),
            .i_wr_index (r_ld_index),
            .i_wr_data  (r_ld_data),
            .i_srch     (w_srch[g]),
            .o_srch     (w_srch[g+1]),
            .i_fetch    (w_fetch[g]),
            .o_fetch    (w_fetch[g+1]),
            .o_busy     (w_busy_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fetch[PALETTE_ENTRIES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {w_fetch[PALETTE_ENTRIES].alpha, w_fetch[PALETTE_ENTRIES].blue,
                      w_fetch[PALETTE_ENTRIES].green, w_fetch[PALETTE_ENTRIES].red};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_load_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && (s_axis_tuser[0] == OP_LOAD)) |=> r_ld_valid)
        else $error("accepted load beat was not parked");

    a_load_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ld_valid && !w_busy) |=> !r_ld_valid)
        else $error("parked load not written once the cell row was empty");

    a_no_pixel_past_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_valid |=> !w_srch[1].valid || !$past(r_ld_valid) || $past(w_adv) == 1'b0
                       || $past(w_srch[1].valid))
        else $error("pixel entered the cell row ahead of a parked load");

    a_out_from_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_fetch[PALETTE_ENTRIES].valid))
        else $error("result beat appeared without a pixel leaving the cell row");
`endif

endmodule

// ----- verif/palette_water_color_remap_top_test.sv -----
`timescale 1ns / 100ps

module palette_water_color_remap_top_test;
    import pwcr_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_CYCLES = 2 * PALETTE_ENTRIES_DEF + 8;
    localparam int RUN_LIMIT_NS = 4_000_000;

    typedef struct {
        logic              opcode;
        logic [3:0]        entry;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              mask;
    } t_item;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_pixel;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BASE_W-1:0] i_cfg_data;

    // Shadow of the block's palette and water base, updated as beats are accepted.
    logic [23:0]       palette_copy [PALETTE_ENTRIES_DEF];
    logic [BASE_W-1:0] water_base_copy;
    t_pixel            expected_pixels [$];
    int                errors;
    bit                src_steady;
    bit                sink_steady;
    int                sink_hold;

    palette_water_color_remap_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned color_dist(input logic [23:0] entry,
                                               input logic [7:0] r, g, b);
        int dr, dg, db;
        dr = int'(entry[23:16]) - int'(r);
        dg = int'(entry[15:8]) - int'(g);
        db = int'(entry[7:0]) - int'(b);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic t_pixel remap_pixel(input t_item it);
        t_pixel      px;
        logic [7:0]  qr, qg, qb;
        logic [3:0]  best_idx;
        logic [3:0]  water_idx;
        int unsigned best_d, d;
        int          i;
        px.red   = it.red;
        px.green = it.green;
        px.blue  = it.blue;
        px.alpha = it.alpha;
        if (it.mask) begin
            // Each channel keeps its top nibble only.
            qr = {it.red[7:4], 4'h0};
            qg = {it.green[7:4], 4'h0};
            qb = {it.blue[7:4], 4'h0};
            best_idx = 4'd0;
            best_d   = color_dist(palette_copy[0], qr, qg, qb);
            for (i = 1; i < PALETTE_ENTRIES_DEF; i++) begin
                d = color_dist(palette_copy[i], qr, qg, qb);
                if (d < best_d) begin
                    best_d   = d;
                    best_idx = 4'(i);
                end
            end
            // The 4-bit sum wraps around the palette.
            water_idx = 4'(water_base_copy + best_idx % WATER_SPAN_DEF);
            px.red   = palette_copy[water_idx][23:16];
            px.green = palette_copy[water_idx][15:8];
            px.blue  = palette_copy[water_idx][7:0];
        end
        return px;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %08h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.red, m_axis_tdata[7:0]);
                check_field("out_green", want.green, m_axis_tdata[15:8]);
                check_field("out_blue", want.blue, m_axis_tdata[23:16]);
                check_field("out_alpha", want.alpha, m_axis_tdata[31:24]);
            end
        end
    end

    // Output side: random stalls, calm stretches, and long hold-offs on request.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (sink_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_beat(input t_item it);
        if (!src_steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, it.alpha, it.blue, it.green, it.red, it.entry};
        s_axis_tuser  <= {it.mask, it.opcode};
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.opcode == OP_PIXEL)
            expected_pixels.insert(expected_pixels.size(), remap_pixel(it));
        else
            palette_copy[it.entry] = {it.red, it.green, it.blue};
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        // A palette load gives no result but may still be waiting inside.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_water_base(input logic [BASE_W-1:0] base);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        water_base_copy = base;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_item(input logic op, input logic [3:0] entry,
                                        input logic [23:0] rgb, input logic [7:0] alpha,
                                        input logic mask);
        t_item it;
        it.opcode = op;
        it.entry  = entry;
        it.red    = rgb[23:16];
        it.green  = rgb[15:8];
        it.blue   = rgb[7:0];
        it.alpha  = alpha;
        it.mask   = mask;
        return it;
    endfunction

    function automatic t_item rand_pixel();
        logic [7:0]  corner_vals [5] = '{8'h00, 8'h0F, 8'h10, 8'hF0, 8'hFF};
        logic [23:0] rgb;
        case ($urandom_range(3))
            0: begin
                // Close to a palette color, same quantized value.
                rgb = palette_copy[$urandom_range(PALETTE_ENTRIES_DEF - 1)]
                      ^ {4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom)};
            end
            1: rgb = {corner_vals[$urandom_range(4)], corner_vals[$urandom_range(4)],
                      corner_vals[$urandom_range(4)]};
            default: rgb = 24'($urandom);
        endcase
        return make_item(OP_PIXEL, 4'($urandom), rgb, 8'($urandom),
                         $urandom_range(99) < 70);
    endfunction

    function automatic t_item rand_load();
        logic [23:0] rgb;
        // Copying another entry now and then sets up distance ties.
        if ($urandom_range(3) == 0)
            rgb = palette_copy[$urandom_range(PALETTE_ENTRIES_DEF - 1)];
        else
            rgb = 24'($urandom);
        return make_item(OP_LOAD, 4'($urandom), rgb, 8'($urandom), 1'($urandom));
    endfunction

    task automatic run_mixed(input int count, input int load_pct);
        repeat (count) begin
            if ($urandom_range(99) < load_pct)
                send_beat(rand_load());
            else
                send_beat(rand_pixel());
        end
    endtask

    // Unmasked pixels before any load, then a full palette with a tie, then masked hits and a last unmasked pixel.
    task automatic test_directed();
        logic [23:0] rgb;
        int          i;
        send_beat(make_item(OP_PIXEL, 4'h0, 24'h000000, 8'h00, 1'b0));
        send_beat(make_item(OP_PIXEL, 4'hF, 24'hFFFFFF, 8'hFF, 1'b0));
        send_beat(make_item(OP_PIXEL, 4'h5, 24'hAA55AA, 8'h5A, 1'b0));
        for (i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
            rgb = {4'(i), 4'h0, 4'(15 - i), 4'h0, 4'(i * 7), 4'h0};
            if (i == 0)
                rgb = 24'h000000;
            else if (i == 1 || i == 2)
                rgb = 24'h404040;
            else if (i == PALETTE_ENTRIES_DEF - 1)
                rgb = 24'hF0F0F0;
            send_beat(make_item(OP_LOAD, 4'(i), rgb, 8'(i), 1'b1));
        end
        send_beat(make_item(OP_PIXEL, 4'h0, 24'h000000, 8'h5A, 1'b1));
        // Entries one and two are equal; the lower index must win.
        send_beat(make_item(OP_PIXEL, 4'h3, 24'h4F4F4F, 8'hA5, 1'b1));
        send_beat(make_item(OP_PIXEL, 4'hF, 24'hFFFFFF, 8'hFF, 1'b1));
        send_beat(make_item(OP_PIXEL, 4'h9, 24'h8C7788, 8'h00, 1'b1));
        send_beat(make_item(OP_PIXEL, 4'hA, 24'h0FF00F, 8'h80, 1'b1));
        send_beat(make_item(OP_PIXEL, 4'h6, 24'h10EF70, 8'h7F, 1'b0));
    endtask

    task automatic test_water_base_sweep();
        logic [BASE_W-1:0] bases [6] = '{4'd0, 4'd15, 4'd12, 4'd13, 4'd14, WATER_BASE_RST};
        int                i;
        for (i = 0; i < 6; i++) begin
            write_water_base(bases[i]);
            run_mixed(30, 0);
        end
    endtask

    task automatic test_random_traffic();
        repeat (5) begin
            write_water_base(4'($urandom));
            run_mixed(150, 8);
        end
    endtask

    task automatic test_steady_stream();
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        run_mixed(150, 5);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // The output is held off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        src_steady = 1'b1;
        sink_hold  = 250;
        run_mixed(120, 3);
        src_steady = 1'b0;
    endtask

    initial begin
        errors          = 0;
        src_steady      = 1'b0;
        sink_steady     = 1'b0;
        sink_hold       = 0;
        water_base_copy = WATER_BASE_RST;
        foreach (palette_copy[i]) palette_copy[i] = 24'h000000;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_water_base_sweep();
        test_random_traffic();
        test_steady_stream();
        test_output_backpressure();
        drain_block();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
